>>> hw/rtl/msrtc_pkg.sv
// ----------------------------------------------------------------------------
// msrtc_pkg - shared types and constants of the speed ramp and turn controller
// Direction and phase codes, register map, configuration and held PWM types.
// ----------------------------------------------------------------------------
package msrtc_pkg;

    localparam int SPEED_W   = 16;
    localparam int TRIM_W    = 7;
    localparam int TIME_W    = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 88;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    localparam int TRIM_PROD_W  = SPEED_W + TRIM_W;
    localparam int TRIM_RECIP_W = 24;
    localparam int TRIM_SHIFT   = 30;
    localparam int TRIM_MUL_W   = TRIM_PROD_W + TRIM_RECIP_W;
    localparam int TRIM_Q_W     = SPEED_W + 1;
    // floor(2^30 / 100) + 1, exact for all products below 2^23
    localparam logic [TRIM_RECIP_W-1:0] TRIM_RECIP = 24'd10737419;

    localparam logic [2:0] REG_RAMP_STEP       = 3'd0;
    localparam logic [2:0] REG_TOP_SPEED       = 3'd1;
    localparam logic [2:0] REG_PIVOT_SPEED     = 3'd2;
    localparam logic [2:0] REG_UPDATE_INTERVAL = 3'd3;
    localparam logic [2:0] REG_PIVOT_MS        = 3'd4;
    localparam logic [2:0] REG_TRIM_PERCENT    = 3'd5;

    typedef enum logic [2:0] {
        DIR_HALT  = 3'd0,
        DIR_FWD   = 3'd1,
        DIR_BWD   = 3'd2,
        DIR_PIV_L = 3'd3,
        DIR_PIV_R = 3'd4
    } dir_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TURN = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [SPEED_W-1:0] ramp_step;
        logic [SPEED_W-1:0] top_speed;
        logic [SPEED_W-1:0] pivot_speed;
        logic [SPEED_W-1:0] update_interval;
        logic [SPEED_W-1:0] pivot_ms;
        logic [TRIM_W-1:0]  trim_percent;
    } cfg_t;

    typedef struct packed {
        logic [SPEED_W-1:0] ch1;
        logic [SPEED_W-1:0] ch2;
        logic [SPEED_W-1:0] ch3;
        logic [SPEED_W-1:0] ch4;
        logic               trim_en;
        logic [TRIM_W-1:0]  trim;
    } pwm_hold_t;

    typedef struct packed {
        pwm_hold_t          hold;
        dir_t               drive_dir;
        logic [SPEED_W-1:0] speed_now;
        logic               turning;
        phase_t             turn_phase;
        logic               updated;
    } rec_t;

    function automatic pwm_hold_t drive_pwm(dir_t dir, logic [SPEED_W-1:0] spd,
                                            logic [SPEED_W-1:0] turn,
                                            logic [TRIM_W-1:0] trim);
        pwm_hold_t h;
        h = '0;
        case (dir)
            DIR_FWD: begin
                h.ch2     = spd;
                h.ch3     = spd;
                h.trim_en = 1'b1;
                h.trim    = trim;
            end
            DIR_BWD: begin
                h.ch1 = spd;
                h.ch4 = spd;
            end
            DIR_PIV_L: h.ch3 = turn;
            DIR_PIV_R: h.ch2 = turn;
            default: ;
        endcase
        return h;
    endfunction

endpackage

>>> hw/rtl/msrtc_cfg_regs.sv
// ----------------------------------------------------------------------------
// msrtc_cfg_regs - configuration register file
// APB-style write and read access to the six ramp and turn settings.
// ----------------------------------------------------------------------------
module msrtc_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [msrtc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [msrtc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [msrtc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output msrtc_pkg::cfg_t                     cfg
);
    import msrtc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_RAMP_STEP:       cfg_next.ramp_step       = pwdata[SPEED_W-1:0];
                REG_TOP_SPEED:       cfg_next.top_speed       = pwdata[SPEED_W-1:0];
                REG_PIVOT_SPEED:     cfg_next.pivot_speed     = pwdata[SPEED_W-1:0];
                REG_UPDATE_INTERVAL: cfg_next.update_interval = pwdata[SPEED_W-1:0];
                REG_PIVOT_MS:        cfg_next.pivot_ms        = pwdata[SPEED_W-1:0];
                REG_TRIM_PERCENT:    cfg_next.trim_percent    = pwdata[TRIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_RAMP_STEP:       prdata = {16'd0, cfg_reg.ramp_step};
            REG_TOP_SPEED:       prdata = {16'd0, cfg_reg.top_speed};
            REG_PIVOT_SPEED:     prdata = {16'd0, cfg_reg.pivot_speed};
            REG_UPDATE_INTERVAL: prdata = {16'd0, cfg_reg.update_interval};
            REG_PIVOT_MS:        prdata = {16'd0, cfg_reg.pivot_ms};
            REG_TRIM_PERCENT:    prdata = {25'd0, cfg_reg.trim_percent};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ramp_step       <= 16'd10;
            cfg_reg.top_speed       <= 16'd1000;
            cfg_reg.pivot_speed     <= 16'd500;
            cfg_reg.update_interval <= 16'd20;
            cfg_reg.pivot_ms        <= 16'd500;
            cfg_reg.trim_percent    <= 7'd98;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/msrtc_ramp_core.sv
// ----------------------------------------------------------------------------
// msrtc_ramp_core - tick register, ramp and pivot rules, controller state
// Registers each tick item, applies the update rules and passes a record on.
// ----------------------------------------------------------------------------
module msrtc_ramp_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  msrtc_pkg::cfg_t                     cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [msrtc_pkg::IN_TDATA_W-1:0]    s_tdata,    // now_ms[31:0], target_dir[34:32]
    output logic                                rec_valid,
    input  logic                                rec_ready,
    output msrtc_pkg::rec_t                     rec
);
    import msrtc_pkg::*;

    logic                in_valid_reg;
    logic [TIME_W-1:0]   in_now_reg;
    logic [2:0]          in_dir_reg;

    logic [TIME_W-1:0]   last_reg,   last_next;
    logic [TIME_W-1:0]   start_reg,  start_next;
    dir_t                dir_reg,    dir_next;
    logic [SPEED_W-1:0]  speed_reg,  speed_next;
    logic [SPEED_W-1:0]  goal_reg,   goal_next;
    logic                right_reg,  right_next;
    logic                active_reg, active_next;
    phase_t              phase_reg,  phase_next;
    pwm_hold_t           hold_reg,   hold_next;

    logic                a_valid_reg;
    rec_t                a_rec_reg;

    logic                a_ready;
    logic                load;
    dir_t                tgt;
    logic [TIME_W-1:0]   elapsed;
    logic [TIME_W-1:0]   turn_elapsed;
    logic                upd;
    logic                cont;
    logic [SPEED_W:0]    ramp_sum;
    logic [SPEED_W-1:0]  step;

    assign a_ready   = !a_valid_reg || rec_ready;
    assign s_tready  = !in_valid_reg || a_ready;
    assign load      = in_valid_reg && a_ready;
    assign rec_valid = a_valid_reg;
    assign rec       = a_rec_reg;

    assign step         = cfg.ramp_step;
    assign tgt          = (in_dir_reg > DIR_PIV_R) ? DIR_HALT : dir_t'(in_dir_reg);
    assign elapsed      = in_now_reg - last_reg;
    assign turn_elapsed = in_now_reg - start_reg;
    assign upd          = load && (elapsed >= {16'd0, cfg.update_interval});
    assign ramp_sum     = {1'b0, speed_reg} + {1'b0, step};

    always_comb begin
        last_next   = last_reg;
        start_next  = start_reg;
        dir_next    = dir_reg;
        speed_next  = speed_reg;
        goal_next   = goal_reg;
        right_next  = right_reg;
        active_next = active_reg;
        phase_next  = phase_reg;
        hold_next   = hold_reg;
        cont        = 1'b1;
        if (upd) begin
            last_next = in_now_reg;
            if (tgt == DIR_HALT && dir_reg != DIR_HALT) begin
                speed_next = '0;
                dir_next   = DIR_HALT;
                hold_next  = '0;
            end else begin
                if (active_reg && phase_reg == PH_TURN) begin
                    if (turn_elapsed >= {16'd0, cfg.pivot_ms}) begin
                        phase_next  = PH_DONE;
                        active_next = 1'b0;
                        dir_next    = DIR_HALT;
                        goal_next   = '0;
                        hold_next   = '0;
                    end else begin
                        hold_next = drive_pwm(dir_t'(right_reg ? DIR_PIV_R : DIR_PIV_L), '0,
                                              cfg.pivot_speed, cfg.trim_percent);
                        cont      = 1'b0;
                    end
                end
                if (cont) begin
                    if (tgt != dir_next) begin
                        goal_next = '0;
                        if (speed_reg != '0) begin
                            speed_next = (speed_reg > step) ? speed_reg - step : '0;
                            hold_next  = drive_pwm(dir_next, speed_next,
                                                   cfg.pivot_speed, cfg.trim_percent);
                        end else begin
                            dir_next = tgt;
                            if (tgt == DIR_PIV_L || tgt == DIR_PIV_R) begin
                                active_next = 1'b1;
                                phase_next  = PH_TURN;
                                right_next  = (tgt == DIR_PIV_R);
                                start_next  = in_now_reg;
                                hold_next   = drive_pwm(tgt, '0, cfg.pivot_speed,
                                                        cfg.trim_percent);
                            end else if (tgt != DIR_HALT) begin
                                goal_next = cfg.top_speed;
                            end
                        end
                    end else if (dir_next != DIR_HALT && !active_next) begin
                        if (speed_reg < goal_next) begin
                            speed_next = (ramp_sum > {1'b0, goal_next}) ? goal_next
                                                                        : ramp_sum[SPEED_W-1:0];
                        end else if (speed_reg > goal_next) begin
                            speed_next = ((speed_reg - goal_next) > step) ? speed_reg - step
                                                                          : goal_next;
                        end
                        hold_next = drive_pwm(dir_next, speed_next, cfg.pivot_speed,
                                              cfg.trim_percent);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            a_valid_reg  <= 1'b0;
            last_reg     <= '0;
            start_reg    <= '0;
            dir_reg      <= DIR_HALT;
            speed_reg    <= '0;
            goal_reg     <= '0;
            right_reg    <= 1'b0;
            active_reg   <= 1'b0;
            phase_reg    <= PH_IDLE;
            hold_reg     <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (a_ready) begin
                a_valid_reg <= in_valid_reg;
            end
            last_reg   <= last_next;
            start_reg  <= start_next;
            dir_reg    <= dir_next;
            speed_reg  <= speed_next;
            goal_reg   <= goal_next;
            right_reg  <= right_next;
            active_reg <= active_next;
            phase_reg  <= phase_next;
            hold_reg   <= hold_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_now_reg <= s_tdata[TIME_W-1:0];
            in_dir_reg <= s_tdata[TIME_W+2:TIME_W];
        end
        if (load) begin
            a_rec_reg.hold       <= hold_next;
            a_rec_reg.drive_dir  <= dir_next;
            a_rec_reg.speed_now  <= speed_next;
            a_rec_reg.turning    <= active_next;
            a_rec_reg.turn_phase <= phase_next;
            a_rec_reg.updated    <= upd;
        end
    end

endmodule

>>> hw/rtl/msrtc_trim_out.sv
// ----------------------------------------------------------------------------
// msrtc_trim_out - forward trim scaling and result register
// Scales channel two by the held trim percent when trim is enabled and packs the result item.
// ----------------------------------------------------------------------------
module msrtc_trim_out (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                rec_valid,
    output logic                                rec_ready,
    input  msrtc_pkg::rec_t                     rec,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [msrtc_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import msrtc_pkg::*;

    logic                    b_valid_reg;
    rec_t                    b_rec_reg;
    logic [TRIM_PROD_W-1:0]  b_prod_reg;

    logic                    out_valid_reg;
    logic [OUT_TDATA_W-1:0]  out_data_reg;

    logic                    c_ready;
    logic [TRIM_MUL_W-1:0]   q_full;
    logic [TRIM_Q_W-1:0]     q;
    logic [SPEED_W-1:0]      ch2;

    assign c_ready   = !out_valid_reg || m_tready;
    assign rec_ready = !b_valid_reg || c_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign q_full = {{TRIM_RECIP_W{1'b0}}, b_prod_reg} * {{TRIM_PROD_W{1'b0}}, TRIM_RECIP};
    assign q      = q_full[TRIM_SHIFT+TRIM_Q_W-1:TRIM_SHIFT];

    always_comb begin
        ch2 = b_rec_reg.hold.ch2;
        if (b_rec_reg.hold.trim_en) begin
            ch2 = q[SPEED_W] ? {SPEED_W{1'b1}} : q[SPEED_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rec_ready) begin
                b_valid_reg <= rec_valid;
            end
            if (c_ready) begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_ready && rec_valid) begin
            b_rec_reg  <= rec;
            b_prod_reg <= {{TRIM_W{1'b0}}, rec.hold.ch2} * {{SPEED_W{1'b0}}, rec.hold.trim};
        end
        if (c_ready && b_valid_reg) begin
            out_data_reg <= {1'b0,
                             b_rec_reg.updated,
                             b_rec_reg.turn_phase,
                             b_rec_reg.turning,
                             b_rec_reg.speed_now,
                             b_rec_reg.drive_dir,
                             b_rec_reg.hold.ch4,
                             b_rec_reg.hold.ch3,
                             ch2,
                             b_rec_reg.hold.ch1};
        end
    end

endmodule

>>> hw/rtl/motor_speed_ramp_turn_controller_unit.sv
// ----------------------------------------------------------------------------
// motor_speed_ramp_turn_controller_unit - speed ramp and pivot turn controller
// Takes one tick item per cycle while m_tready is high and returns the H-bridge compare values.
// ----------------------------------------------------------------------------
// An accepted tick item passes the tick register, the rule stage, the trim
// product stage and the result register to m_tdata. Throughput: one item per
// cycle while m_tready is high; each stage passes one item a cycle unless stalled.
// Reset (aresetn low, synchronous): stopped, speed zero, no turn, all compare
// values zero, settings back to their defaults, pipeline emptied.
// ----------------------------------------------------------------------------
module motor_speed_ramp_turn_controller_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [msrtc_pkg::IN_TDATA_W-1:0]    s_tdata,    // now_ms, target_dir, zero pad
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pwm_ch1, pwm_ch2, pwm_ch3, pwm_ch4, drive_dir, speed_now, turning,
    // turn_phase, updated, zero pad
    output logic [msrtc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [msrtc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [msrtc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [msrtc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import msrtc_pkg::*;

    cfg_t cfg;
    logic rec_valid;
    logic rec_ready;
    rec_t rec;

    msrtc_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    msrtc_ramp_core u_ramp_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    msrtc_trim_out u_trim_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
